// ===== hw/rtl/pst_pkg.sv =====
package pst_pkg;

    localparam int PST_MAX_PROCS = 16;
    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int PRIO_W = 8;
    localparam int DONE_W = 23;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 120;

    // layout matches the input tdata, proc_id in the lowest bits
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   proc_id;
    } rec_t;

    typedef struct packed {
        logic ins;    // sorted insert of the incoming record
        logic shift;  // drain: every cell takes its right neighbor
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic gt;     // empty or holding a larger prio than the incoming one
        rec_t rec;
    } cell_out_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

// ===== hw/rtl/priority_schedule_times_top.sv =====
// Loading: one record per cycle, the first MAX_PROCS inserted in prio order into
// the cell row. Draining: once the tlast item has set the drain state and the
// first result is registered, one result per cycle while m_axis_tready is high;
// the row shifts one cell toward the output. s_axis_tready is low from the tlast
// item until the last result is loaded. aresetn (synchronous) empties the row and
// the output register; stored records beyond the valid cells are not cleared.
module priority_schedule_times_top #(
    parameter int MAX_PROCS = pst_pkg::PST_MAX_PROCS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [pst_pkg::IN_W-1:0]  s_axis_tdata,  // proc_id, arrival, burst, prio
    input  logic                      s_axis_tlast,  // last_in
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_id, out_arrival, out_burst, out_prio, completion, turnaround, waiting, 3 pad
    output logic [pst_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast   // last_out
);
    import pst_pkg::*;

    localparam int CW = $clog2(MAX_PROCS + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          acc, ins, adv, shift, clr;
    cell_ctl_t     ctl;
    rec_t          new_rec;
    cell_out_t     cells [MAX_PROCS];
    cell_out_t     edge_l, edge_r;

    assign new_rec       = rec_t'(s_axis_tdata);
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign ins           = acc && (count_reg < CW'(MAX_PROCS));
    assign clr           = acc && s_axis_tlast;
    assign shift         = (state_reg == ST_DRAIN) && adv;
    assign ctl.ins       = ins;
    assign ctl.shift     = shift;

    // left of cell 0 never claims the slot; right of the end is empty
    assign edge_l = '{valid: 1'b0, gt: 1'b0, rec: '0};
    assign edge_r = '{valid: 1'b0, gt: 1'b1, rec: '0};

    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        pst_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .new_rec (new_rec),
            .left    ((i == 0) ? edge_l : cells[(i == 0) ? 0 : i-1]),
            .right   ((i == MAX_PROCS-1) ? edge_r : cells[(i == MAX_PROCS-1) ? i : i+1]),
            .slot    (cells[i])
        );
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        case (state_reg)
            ST_LOAD: begin
                if (ins) begin
                    count_next = count_reg + CW'(1);
                end
                if (clr) begin
                    state_next  = ST_DRAIN;
                    remain_next = ins ? count_reg + CW'(1) : count_reg;
                    count_next  = '0;
                end
            end
            ST_DRAIN: begin
                if (adv) begin
                    remain_next = remain_reg - CW'(1);
                    if (remain_reg == CW'(1)) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    pst_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clr           (clr),
        .load          (shift),
        .last          (remain_reg == CW'(1)),
        .rec           (cells[0].rec),
        .adv           (adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/pst_cell.sv =====
module pst_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  pst_pkg::cell_ctl_t ctl,
    input  pst_pkg::rec_t     new_rec,
    input  pst_pkg::cell_out_t left,
    input  pst_pkg::cell_out_t right,
    output pst_pkg::cell_out_t slot
);
    import pst_pkg::*;

    logic valid_reg, valid_next;
    rec_t rec_reg, rec_next;
    logic gt;

    // equal prio does not count, so equal entries keep their load order
    assign gt = !valid_reg || (rec_reg.prio > new_rec.prio);

    always_comb begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctl.shift) begin
            valid_next = right.valid;
            rec_next   = right.rec;
        end else if (ctl.ins && gt) begin
            if (left.gt) begin
                valid_next = left.valid;
                rec_next   = left.rec;
            end else begin
                valid_next = 1'b1;
                rec_next   = new_rec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign slot.valid = valid_reg;
    assign slot.gt    = gt;
    assign slot.rec   = rec_reg;

endmodule

// ===== hw/rtl/pst_out.sv =====
module pst_out (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      clr,
    input  logic                      load,
    input  logic                      last,
    input  pst_pkg::rec_t             rec,
    output logic                      adv,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [pst_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);
    import pst_pkg::*;

    logic              valid_reg, valid_next;
    logic [DONE_W-1:0] done_reg, done_next;
    logic [DONE_W-1:0] start, comp, tat, wait_t;
    logic [DONE_W-1:0] arr_x, bur_x;
    rec_t              rec_reg;
    logic [DONE_W-1:0] comp_reg, tat_reg, wait_reg;
    logic              last_reg;

    assign adv   = !valid_reg || m_axis_tready;
    assign arr_x = {{(DONE_W-TIME_W){1'b0}}, rec.arrival};
    assign bur_x = {{(DONE_W-TIME_W){1'b0}}, rec.burst};

    // idle gap: the cpu waits for the arrival
    assign start  = (done_reg > arr_x) ? done_reg : arr_x;
    assign comp   = start + bur_x;
    assign wait_t = start - arr_x;
    assign tat    = wait_t + bur_x;

    always_comb begin
        valid_next = valid_reg;
        done_next  = done_reg;
        if (load) begin
            valid_next = 1'b1;
            done_next  = comp;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
        if (clr) begin
            done_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg  <= rec;
            comp_reg <= comp;
            tat_reg  <= tat;
            wait_reg <= wait_t;
            last_reg <= last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_W-IN_W-3*DONE_W){1'b0}}, wait_reg, tat_reg, comp_reg,
                            rec_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// ===== hw/rtl/pst_checker.sv =====
module pst_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [pst_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      s_axis_tlast,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [pst_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_close_set: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after the closing item");

    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while loading");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind priority_schedule_times_top pst_checker u_pst_checker (.*);
